/* rtl/core/stbs_pkg.sv */
// shared types, constants and the microcode rom of the sorted table search core
package stbs_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);
  localparam int WORD_W      = 32;

  // request modes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // input request
  typedef struct packed {
    logic                     mode;
    logic [IDX_W-1:0]         entry_index;
    logic signed [WORD_W-1:0] entry_value;
    logic signed [WORD_W-1:0] search_key;
  } in_req_t;

  // result request
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] position;
  } out_req_t;

  // microprogram steps
  typedef enum logic [2:0] {
    STEP_FETCH   = 3'd0,
    STEP_INIT    = 3'd1,
    STEP_FIRST   = 3'd2,
    STEP_COMPARE = 3'd3,
    STEP_EMIT    = 3'd4
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    JC_NONE     = 3'd0,
    JC_SEARCH   = 3'd1,
    JC_EMPTY    = 3'd2,
    JC_DONE     = 3'd3,
    JC_OUT_FREE = 3'd4
  } jcond_t;

  // one control word
  typedef struct packed {
    logic   accept;
    logic   init;
    logic   first;
    logic   compare;
    logic   emit;
    logic   hold;
    jcond_t cond;
    step_t  target;
  } ctrl_word_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic search_acc;
    logic empty;
    logic done;
    logic out_free;
  } stat_t;

  // microcode rom
  function automatic ctrl_word_t ucode_rom(input step_t step);
    ctrl_word_t cw;
    cw = '0;
    cw.cond   = JC_NONE;
    cw.target = STEP_FETCH;
    unique case (step)
      STEP_FETCH: begin
        cw.accept = 1'b1;
        cw.hold   = 1'b1;
        cw.cond   = JC_SEARCH;
        cw.target = STEP_INIT;
      end
      STEP_INIT: begin
        cw.init = 1'b1;
      end
      STEP_FIRST: begin
        cw.first  = 1'b1;
        cw.cond   = JC_EMPTY;
        cw.target = STEP_EMIT;
      end
      STEP_COMPARE: begin
        cw.compare = 1'b1;
        cw.hold    = 1'b1;
        cw.cond    = JC_DONE;
        cw.target  = STEP_EMIT;
      end
      STEP_EMIT: begin
        cw.emit   = 1'b1;
        cw.hold   = 1'b1;
        cw.cond   = JC_OUT_FREE;
        cw.target = STEP_FETCH;
      end
      default: begin
        cw.cond   = JC_NONE;
        cw.hold   = 1'b0;
        cw.target = STEP_FETCH;
      end
    endcase
    return cw;
  endfunction

endpackage

/* rtl/core/stbs_seq.sv */
// microcode sequencer: step counter, control rom and conditional jumps
module stbs_seq import stbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  stat_t      stat,
  output ctrl_word_t cw
);

  step_t step_r, step_nxt;
  logic  jump;

  // control word of the current step
  assign cw = ucode_rom(step_r);

  // jump condition select
  always_comb begin
    unique case (cw.cond)
      JC_NONE:     jump = 1'b0;
      JC_SEARCH:   jump = stat.search_acc;
      JC_EMPTY:    jump = stat.empty;
      JC_DONE:     jump = stat.done;
      JC_OUT_FREE: jump = stat.out_free;
      default:     jump = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    priority if (jump) begin
      step_nxt = cw.target;
    end else if (cw.hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = step_t'(step_r + 3'd1);
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

/* rtl/core/stbs_dp.sv */
// datapath: entry memory, search bounds, key compare and result register
module stbs_dp import stbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_word_t        cw,
  input  logic              in_valid,
  input  in_req_t           in_req,
  input  logic              cfg_valid,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic              out_stall,
  output stat_t             stat,
  output logic              out_valid,
  output out_req_t          out_req
);

  logic signed [WORD_W-1:0] entries [TABLE_DEPTH];

  logic [SIZE_W-1:0]        size_r;
  logic [SIZE_W-1:0]        n_sat;
  logic [SIZE_W-1:0]        lo_r, hi_r, lo_nxt, hi_nxt;
  logic [IDX_W-1:0]         mid_r, rd_addr;
  logic signed [WORD_W-1:0] key_r, rd_data_r;
  logic                     hit_r;
  logic [IDX_W-1:0]         pos_r;
  logic                     out_valid_r;
  out_req_t                 out_req_r;
  logic                     in_fire, gt, lt, eq;

  // midpoint of a non-empty half-open interval
  function automatic logic [IDX_W-1:0] mid_of(input logic [SIZE_W-1:0] lo,
                                              input logic [SIZE_W-1:0] hi);
    logic [SIZE_W:0] sum;
    sum = {1'b0, lo} + {1'b0, hi} - {{SIZE_W{1'b0}}, 1'b1};
    return sum[IDX_W:1];
  endfunction

  assign in_fire = in_valid && cw.accept;

  // size saturates at the table depth
  assign n_sat = (size_r > SIZE_W'(TABLE_DEPTH)) ? SIZE_W'(TABLE_DEPTH) : size_r;

  // probe compare and bound update
  assign gt     = rd_data_r > key_r;
  assign lt     = rd_data_r < key_r;
  assign eq     = !gt && !lt;
  assign lo_nxt = lt ? (SIZE_W'(mid_r) + SIZE_W'(1)) : lo_r;
  assign hi_nxt = gt ? SIZE_W'(mid_r) : hi_r;
  assign rd_addr = cw.first ? mid_of(lo_r, hi_r) : mid_of(lo_nxt, hi_nxt);

  // status to the sequencer
  assign stat.search_acc = in_fire && (in_req.mode == MODE_SEARCH);
  assign stat.empty      = lo_r >= hi_r;
  assign stat.done       = eq || (lo_nxt >= hi_nxt);
  assign stat.out_free   = !out_valid_r || !out_stall;

  // entry memory
  always_ff @(posedge clk) begin
    if (in_fire && (in_req.mode == MODE_WRITE)) begin
      entries[in_req.entry_index] <= in_req.entry_value;
    end
    rd_data_r <= entries[rd_addr];
  end

  // size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
    end else if (cfg_valid) begin
      size_r <= cfg_data;
    end
  end

  // search registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_r <= in_req.search_key;
    end
    if (cw.init) begin
      lo_r <= '0;
      hi_r <= n_sat;
    end
    if (cw.first) begin
      mid_r <= rd_addr;
      hit_r <= 1'b0;
      pos_r <= '0;
    end
    if (cw.compare) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      mid_r <= rd_addr;
      hit_r <= eq;
      pos_r <= eq ? mid_r : '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cw.emit && stat.out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.emit && stat.out_free) begin
      out_req_r.found    <= hit_r;
      out_req_r.position <= pos_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

/* rtl/core/sorted_table_binary_search_core.sv */
// top level of the sorted table binary search core
//
//  channel | direction | handshake            | request
//  in_     | input     | in_valid / in_stall  | in_req_t: write entry or search key
//  out_    | output    | out_valid / out_stall| out_req_t: found flag and position
//  cfg_    | input     | cfg_valid / cfg_ready| table_size, 11 bits
//
// a write request is taken in the fetch step; a search runs the init and first steps,
// then one compare step per probe, each with one memory read, and the emit step
// one request is handled at a time; in_stall is high outside the fetch step
// a finished result waits in the output register while out_stall is high
// synchronous reset clears the step counter, table_size and out_valid;
// table entries are undefined until written

module sorted_table_binary_search_core import stbs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_req_t           in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output out_req_t          out_req,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  ctrl_word_t cw;
  stat_t      stat;

  // sequencer
  stbs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cw    (cw)
  );

  // datapath
  stbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cw        (cw),
    .in_valid  (in_valid),
    .in_req    (in_req),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_req   (out_req)
  );

  // handshake outputs
  assign in_stall  = !cw.accept;
  assign cfg_ready = 1'b1;

endmodule

/* rtl/core/stbs_checker.sv */
// port-level checker for the sorted table binary search core, with its bind
module stbs_checker import stbs_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input in_req_t  in_req,
  input logic     out_valid,
  input logic     out_stall,
  input out_req_t out_req
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_req))
    else $error("result changed while stalled");

  // a miss reports position zero
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_req.found |-> out_req.position == '0)
    else $error("miss with non-zero position");

  // an accepted search occupies the core in the following cycle
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req.mode == MODE_SEARCH) |=> in_stall)
    else $error("request taken during a search");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_req   (out_req)
);
